// ----- hdl/bit_pkg.sv -----
// shared types, constants and the deletion test for the binary image thinning core
// no dependencies
`default_nettype none
package bit_pkg;
   localparam int MaxWidthDef  = 512;
   localparam int MaxHeightDef = 512;
   localparam int IdxW   = 18;
   localparam int CountW = 19;
   localparam int GeoW   = 10;
   localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_THIN = 2'd1,
      CMD_READ = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_THRESH = 2'd2;

   // zhang-suen deletion test on the eight neighbors p[0]=north, clockwise
   function automatic logic zs_delete(input logic [7:0] p, input logic phase);
      logic [3:0] b;
      logic [3:0] a;
      logic ok;
      b = 4'd0;
      a = 4'd0;
      for (int i = 0; i < 8; i++) begin
         b = b + {3'd0, p[i]};
         if (!p[i] && p[(i + 1) % 8]) a = a + 4'd1;
      end
      ok = (b >= 4'd2) && (b <= 4'd6) && (a == 4'd1);
      if (!phase) ok = ok && !(p[0] && p[2] && p[4]) && !(p[2] && p[4] && p[6]);
      else        ok = ok && !(p[0] && p[2] && p[6]) && !(p[0] && p[4] && p[6]);
      return ok;
   endfunction
endpackage
`default_nettype wire

// ----- hdl/bit_mem.sv -----
// single-port bit memory with registered read, holds one binary image
// depends on nothing
`default_nettype none
module bit_mem #(
   parameter int Depth = 262144,
   parameter int AddrW = 18
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] addr,
   input  wire logic             wr_data,
   output logic                  rd_data
);
   logic mem [Depth];

   // write or read one bit per cycle
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ----- hdl/binary_image_thinning_core.sv -----
// Binary image thinning core. A load request binarizes one grey byte and stores it at a
// row-major index (no response) and the block is ready again on the next cycle; a read request
// registers its response in S_READ from the memory bit captured at the accepting edge, then
// holds it in S_RESP until the handshake; a thin request runs Zhang-Suen thinning on the
// single-port image memory until an iteration deletes nothing and returns the iteration count.
// The shared sequencer and one memory port set the rate: each sub-pass visits every interior
// pixel, reading its 9 neighborhood bits one per cycle, then sweeps the interior again through
// a one-bit mark memory to apply deletions. Every mark that the apply sweep reads was written
// earlier in the same sub-pass, so no clearing pass after reset is needed. The block takes no
// request while one is in progress.
// depends on bit_pkg and bit_mem
`default_nettype none
module binary_image_thinning_core #(
   parameter int MAX_WIDTH  = bit_pkg::MaxWidthDef,
   parameter int MAX_HEIGHT = bit_pkg::MaxHeightDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [17:0] req_pixel_index,
   input  wire logic [7:0]  req_grey_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_pixel_bit,
   output logic [18:0]      rsp_iteration_count,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_data
);
   import bit_pkg::*;

   localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(Depth);
   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int PW    = AW + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_CENTER, S_NBR, S_DECIDE,
      S_APPLY_RD, S_APPLY_WAIT, S_APPLY_WR, S_ITER, S_RESP
   } state_type;

   state_type       state_ff;
   logic [GeoW-1:0] width_ff, height_ff;
   logic [7:0]      thresh_ff;
   logic [CountW-1:0] count_ff, last_ff;
   logic [XW-1:0]   x_ff;
   logic [YW-1:0]   y_ff;
   logic [3:0]      k_ff;
   logic [7:0]      nbr_ff;
   logic            phase_ff, any_ff, bit_ff, pend_ff;
   logic [PW-1:0]   lin_ff;

   // effective geometry
   logic [XW-1:0] w_eff;
   logic [YW-1:0] h_eff;
   logic [PW-1:0] limit;
   logic [IdxW:0] req_idx_ext;
   logic          in_range;
   assign w_eff = ({22'd0, width_ff} > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(width_ff);
   assign h_eff = ({22'd0, height_ff} > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(height_ff);
   assign limit = PW'(w_eff) * PW'(h_eff);
   assign req_idx_ext = {1'b0, req_pixel_index};
   assign in_range = (PW'(req_idx_ext) < limit) && (32'(req_pixel_index) < 32'(Depth))
                     && (req_idx_ext < (IdxW+1)'(limit) || PW > IdxW + 1);

   logic accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // neighbor offset for step k: 0 center, 1..8 = p[0]..p[7]
   logic signed [PW:0] off;
   logic signed [PW:0] wsx;
   assign wsx = (PW+1)'(w_eff);
   always_comb begin
      case (k_ff)
         4'd1:    off = -wsx;
         4'd2:    off = -wsx + (PW+1)'(1);
         4'd3:    off = (PW+1)'(1);
         4'd4:    off = wsx + (PW+1)'(1);
         4'd5:    off = wsx;
         4'd6:    off = wsx - (PW+1)'(1);
         4'd7:    off = -(PW+1)'(1);
         4'd8:    off = -wsx - (PW+1)'(1);
         default: off = '0;
      endcase
   end

   // image memory port
   logic          img_we, img_wd, img_rd;
   logic [AW-1:0] img_addr;
   logic          mk_we, mk_wd, mk_rd;
   logic [AW-1:0] nb_addr;
   assign nb_addr = AW'($signed({1'b0, lin_ff}) + off);

   always_comb begin
      img_we   = 1'b0;
      img_wd   = 1'b0;
      img_addr = lin_ff[AW-1:0];
      mk_we    = 1'b0;
      mk_wd    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            img_addr = AW'(req_pixel_index);
            img_we   = accept && (cmd_type'(req_cmd) == CMD_LOAD) && in_range;
            img_wd   = req_grey_value > thresh_ff;
         end
         S_CENTER, S_NBR: img_addr = nb_addr;
         S_DECIDE: begin
            mk_we = 1'b1;
            mk_wd = bit_ff && zs_delete(nbr_ff, phase_ff);
         end
         S_APPLY_WR: begin
            img_we = mk_rd;
            img_wd = 1'b0;
         end
         default: ;
      endcase
   end

   bit_mem #(.Depth(Depth), .AddrW(AW)) u_img (
      .clock(clock), .wr_en(img_we), .addr(img_addr), .wr_data(img_wd), .rd_data(img_rd));
   bit_mem #(.Depth(Depth), .AddrW(AW)) u_mark (
      .clock(clock), .wr_en(mk_we), .addr(lin_ff[AW-1:0]), .wr_data(mk_wd), .rd_data(mk_rd));

   logic last_x, last_y, tiny;
   assign last_x = ({1'b0, x_ff} + 1'b1) + 1'b1 >= {1'b0, w_eff};
   assign last_y = ({1'b0, y_ff} + 1'b1) + 1'b1 >= {1'b0, h_eff};
   assign tiny   = (w_eff < XW'(3)) || (h_eff < YW'(3));

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         width_ff  <= GeoW'(512);
         height_ff <= GeoW'(512);
         thresh_ff <= 8'd127;
         last_ff   <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_WIDTH:  width_ff  <= csr_data;
               CSR_HEIGHT: height_ff <= csr_data;
               CSR_THRESH: thresh_ff <= csr_data[7:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: if (accept) begin
               unique case (cmd_type'(req_cmd))
                  CMD_READ: begin
                     pend_ff  <= in_range;
                     state_ff <= S_READ;
                  end
                  CMD_THIN: begin
                     count_ff <= '0;
                     phase_ff <= 1'b0;
                     any_ff   <= 1'b0;
                     x_ff     <= XW'(1);
                     y_ff     <= YW'(1);
                     lin_ff   <= PW'(w_eff) + PW'(1);
                     k_ff     <= 4'd0;
                     state_ff <= tiny ? S_ITER : S_CENTER;
                  end
                  default: ;
               endcase
            end
            // read data registered at the accepting edge is on the port now
            S_READ: begin
               rsp_pixel_bit       <= pend_ff && img_rd;
               rsp_iteration_count <= last_ff;
               rsp_valid           <= 1'b1;
               state_ff            <= S_RESP;
            end
            S_CENTER: begin
               k_ff     <= 4'd1;
               state_ff <= S_NBR;
            end
            S_NBR: begin
               // data for step k-1 arrives now
               if (k_ff == 4'd1) bit_ff <= img_rd;
               else nbr_ff[3'(k_ff - 4'd2)] <= img_rd;
               if (k_ff == 4'd9) state_ff <= S_DECIDE;
               else k_ff <= k_ff + 4'd1;
            end
            S_DECIDE: begin
               if (bit_ff && zs_delete(nbr_ff, phase_ff)) any_ff <= 1'b1;
               k_ff <= 4'd0;
               if (last_x) begin
                  x_ff <= XW'(1);
                  if (last_y) begin
                     y_ff     <= YW'(1);
                     lin_ff   <= PW'(w_eff) + PW'(1);
                     state_ff <= S_APPLY_RD;
                  end else begin
                     y_ff     <= y_ff + 1'b1;
                     lin_ff   <= lin_ff + PW'(3);
                     state_ff <= S_CENTER;
                  end
               end else begin
                  x_ff     <= x_ff + 1'b1;
                  lin_ff   <= lin_ff + PW'(1);
                  state_ff <= S_CENTER;
               end
            end
            S_APPLY_RD: state_ff <= S_APPLY_WAIT;
            S_APPLY_WAIT: state_ff <= S_APPLY_WR;
            // apply sweep walks the interior only, where every mark is fresh
            S_APPLY_WR: begin
               if (last_x) begin
                  x_ff <= XW'(1);
                  if (last_y) begin
                     phase_ff <= ~phase_ff;
                     y_ff     <= YW'(1);
                     lin_ff   <= PW'(w_eff) + PW'(1);
                     state_ff <= phase_ff ? S_ITER : S_CENTER;
                  end else begin
                     y_ff     <= y_ff + 1'b1;
                     lin_ff   <= lin_ff + PW'(3);
                     state_ff <= S_APPLY_RD;
                  end
               end else begin
                  x_ff     <= x_ff + 1'b1;
                  lin_ff   <= lin_ff + PW'(1);
                  state_ff <= S_APPLY_RD;
               end
            end
            S_ITER: begin
               if (count_ff != CountMax) count_ff <= count_ff + 1'b1;
               if (any_ff && !tiny) begin
                  any_ff   <= 1'b0;
                  phase_ff <= 1'b0;
                  state_ff <= S_CENTER;
               end else begin
                  last_ff             <= (count_ff != CountMax) ? count_ff + 1'b1 : count_ff;
                  rsp_pixel_bit       <= 1'b0;
                  rsp_iteration_count <= (count_ff != CountMax) ? count_ff + 1'b1 : count_ff;
                  rsp_valid           <= 1'b1;
                  state_ff            <= S_RESP;
               end
            end
            S_RESP: if (!rsp_stall) begin
               rsp_valid <= 1'b0;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   // no request taken while a response is pending
   a_busy: assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("request accepted with response pending");
   // response leaves only through handshake
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_iteration_count))
      else $error("response dropped under stall");
   // marks only written during decision
   a_mark: assert property (@(posedge clock) disable iff (reset)
      mk_we |-> state_ff == S_DECIDE) else $error("stray mark write");
`endif
endmodule
`default_nettype wire
